>>> sv/phx_pkg.sv
package phx_pkg;

   localparam int WORD_W     = 32;
   localparam int DWORD_W    = 64;
   localparam int ACTION_W   = 2;
   localparam int CSR_AW     = 6;
   localparam int CSR_DW     = 64;
   localparam int MAC_WORDS  = 4;
   localparam int MAC_PREMIX = 8;
   localparam int CNT_W      = 4;
   localparam int UPC_W      = 5;

   localparam logic [WORD_W-1:0] MAC_MAGIC = 32'h912D94F1;

   typedef logic [WORD_W-1:0]     word_type;
   typedef logic [4:0][WORD_W-1:0] mix_type;
   typedef logic [UPC_W-1:0]      upc_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONCE   = 2'd0,
      ACT_ENCRYPT = 2'd1,
      ACT_FINAL   = 2'd2,
      ACT_UNUSED  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CSR_KEY01 = 3'd0,
      CSR_KEY23 = 3'd1,
      CSR_KEY45 = 3'd2,
      CSR_KEY67 = 3'd3,
      CSR_BUMP  = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_INIT,
      OP_HALF_A,
      OP_HALF_B,
      OP_SAVE,
      OP_RESTORE
   } op_type;

   typedef enum logic [1:0] {
      X_ZERO,
      X_KEY,
      X_PLAIN,
      X_SCHED
   } x_sel_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_CIPHER,
      EMIT_MAC
   } emit_type;

   typedef enum logic {
      CNT_PREMIX,
      CNT_MAC
   } cnt_sel_type;

   typedef struct packed {
      op_type      op;
      x_sel_type   x_sel;
      logic        ks_cap;
      logic        old_wr;
      emit_type    emit;
      logic        cnt_load;
      cnt_sel_type cnt_sel;
      logic        loop;
      upc_type     target;
      logic        done;
   } uop_type;

   // Program entry points.
   localparam upc_type ENTRY_NONCE   = 5'd0;
   localparam upc_type ENTRY_ENCRYPT = 5'd5;
   localparam upc_type ENTRY_FINAL   = 5'd9;
   localparam upc_type ENTRY_IGNORE  = 5'd19;
   // Loop heads.
   localparam upc_type LOOP_NONCE    = 5'd1;
   localparam upc_type LOOP_PREMIX   = 5'd10;
   localparam upc_type LOOP_MAC      = 5'd14;

   function automatic word_type rotl(input word_type v, input int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic mix_type half_a(input mix_type z, input word_type x);
      word_type a0, a1, a2, a3, a4;
      mix_type  r;
      a0 = z[0] + (z[3] ^ x);
      a1 = z[1] + z[4];
      a2 = z[2] ^ a0;
      a3 = rotl(z[3], 15) ^ a1;
      a4 = rotl(z[4], 25) + a2;
      r[0] = rotl(a0, 9);
      r[1] = rotl(a1, 10);
      r[2] = rotl(a2, 17);
      r[3] = a3;
      r[4] = a4;
      return r;
   endfunction

   function automatic mix_type half_b(input mix_type z, input word_type x);
      word_type b0, b1, b2, b3, b4;
      mix_type  r;
      b0 = z[0] ^ (z[3] + x);
      b1 = z[1] ^ z[4];
      b2 = z[2] + b0;
      b3 = rotl(z[3], 30) + b1;
      b4 = rotl(z[4], 13) ^ b2;
      r[0] = rotl(b0, 20);
      r[1] = rotl(b1, 11);
      r[2] = rotl(b2, 5);
      r[3] = b3;
      r[4] = b4;
      return r;
   endfunction

   // Microprogram. One mixing word is four steps: two halves ending with the key
   // schedule, then two halves ending with the second schedule; encrypt feeds the plaintext into the third.
   function automatic uop_type ucode(input upc_type pc);
      uop_type u;
      u.op       = OP_NOP;
      u.x_sel    = X_ZERO;
      u.ks_cap   = 1'b0;
      u.old_wr   = 1'b0;
      u.emit     = EMIT_NONE;
      u.cnt_load = 1'b0;
      u.cnt_sel  = CNT_PREMIX;
      u.loop     = 1'b0;
      u.target   = ENTRY_NONCE;
      u.done     = 1'b0;
      case (pc)
         // Nonce setup: build schedules and state, then eight mixing words.
         5'd0: begin
            u.op = OP_INIT;
            u.cnt_load = 1'b1;
            u.cnt_sel = CNT_PREMIX;
         end
         5'd1: begin
            u.op = OP_HALF_A;
         end
         5'd2: begin
            u.op = OP_HALF_B;
            u.x_sel = X_KEY;
         end
         5'd3: begin
            u.op = OP_HALF_A;
         end
         5'd4: begin
            u.op = OP_HALF_B;
            u.x_sel = X_SCHED;
            u.old_wr = 1'b1;
            u.loop = 1'b1;
            u.target = LOOP_NONCE;
            u.done = 1'b1;
         end
         // Encrypt one word.
         5'd5: begin
            u.op = OP_HALF_A;
         end
         5'd6: begin
            u.op = OP_HALF_B;
            u.x_sel = X_KEY;
         end
         5'd7: begin
            u.op = OP_HALF_A;
            u.x_sel = X_PLAIN;
            u.ks_cap = 1'b1;
         end
         5'd8: begin
            u.op = OP_HALF_B;
            u.x_sel = X_SCHED;
            u.old_wr = 1'b1;
            u.emit = EMIT_CIPHER;
            u.done = 1'b1;
         end
         // Finalize: save state, premix, emit the MAC words, then restore the state.
         5'd9: begin
            u.op = OP_SAVE;
            u.cnt_load = 1'b1;
            u.cnt_sel = CNT_PREMIX;
         end
         5'd10: begin
            u.op = OP_HALF_A;
         end
         5'd11: begin
            u.op = OP_HALF_B;
            u.x_sel = X_KEY;
         end
         5'd12: begin
            u.op = OP_HALF_A;
         end
         5'd13: begin
            u.op = OP_HALF_B;
            u.x_sel = X_SCHED;
            u.old_wr = 1'b1;
            u.loop = 1'b1;
            u.target = LOOP_PREMIX;
            u.cnt_load = 1'b1;
            u.cnt_sel = CNT_MAC;
         end
         5'd14: begin
            u.op = OP_HALF_A;
         end
         5'd15: begin
            u.op = OP_HALF_B;
            u.x_sel = X_KEY;
         end
         5'd16: begin
            u.op = OP_HALF_A;
            u.ks_cap = 1'b1;
         end
         5'd17: begin
            u.op = OP_HALF_B;
            u.x_sel = X_SCHED;
            u.old_wr = 1'b1;
            u.emit = EMIT_MAC;
            u.loop = 1'b1;
            u.target = LOOP_MAC;
         end
         5'd18: begin
            u.op = OP_RESTORE;
            u.done = 1'b1;
         end
         // Unused action code, and any address outside the program.
         default: begin
            u.done = 1'b1;
         end
      endcase
      return u;
   endfunction

endpackage

>>> sv/phx_req_if.sv
interface phx_req_if;
   logic                            valid;
   logic                            ready;
   logic [phx_pkg::ACTION_W-1:0]    action;
   logic [phx_pkg::DWORD_W-1:0]     nonce_low;
   logic [phx_pkg::DWORD_W-1:0]     nonce_high;
   logic [phx_pkg::WORD_W-1:0]      plain_word;

   modport source (output valid, action, nonce_low, nonce_high, plain_word, input ready);
   modport sink (input valid, action, nonce_low, nonce_high, plain_word, output ready);
endinterface

>>> sv/phx_rsp_if.sv
interface phx_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [phx_pkg::WORD_W-1:0]      data_word;
   logic                            is_mac;
   logic                            last;

   modport source (output valid, data_word, is_mac, last, input ready);
   modport sink (input valid, data_word, is_mac, last, output ready);
endinterface

>>> sv/phelix_word_stream_cipher_mac_unit.sv
// Phelix-style word cipher with MAC. The key schedule (four 64-bit registers
// at byte addresses 0, 8, 16 and 24) and the second-schedule bump (address 32)
// are to be written over the APB port only while the block is idle; the block
// itself does not enforce this. Each request beat carries an action. A nonce
// setup beat builds the schedules and the mixing state and gives no response.
// An encrypt beat gives one ciphertext beat with last set; it takes one step
// per half round, and the next request is taken in the same cycle as its
// fourth step. A finalize beat gives the MAC words as response beats with
// is_mac set and last on the final one, leaving the stored state unchanged.
// The unused action code gives nothing. A response waiting in the output
// register stalls the sequencer only at a step that emits, and only while
// the response side holds ready low.
module phelix_word_stream_cipher_mac_unit (
   input  logic                          clock,
   input  logic                          reset,
   phx_req_if.sink                       req_ch,
   phx_rsp_if.source                     rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [phx_pkg::CSR_AW-1:0]    paddr,
   input  logic [phx_pkg::CSR_DW-1:0]    pwdata,
   output logic [phx_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   // Configuration registers.
   logic [3:0][phx_pkg::DWORD_W-1:0]  key_ff;
   phx_pkg::word_type                 bump_ff;

   // Cipher state, updated in place by nonce setup and encrypt; finalize restores it at its end.
   phx_pkg::mix_type                  z_ff, z_in;
   logic [3:0][phx_pkg::WORD_W-1:0]   old_ff, old_in;
   logic [7:0][phx_pkg::WORD_W-1:0]   ss_ff, ss_in;
   phx_pkg::word_type                 idx_ff, idx_in;

   // Copy of the state taken at the start of finalize and put back at its end.
   phx_pkg::mix_type                  zsave_ff;
   logic [3:0][phx_pkg::WORD_W-1:0]   oldsave_ff;
   phx_pkg::word_type                 idxsave_ff;

   // Latched request payload.
   logic [3:0][phx_pkg::WORD_W-1:0]   nonce_ff;
   phx_pkg::word_type                 plain_ff;
   phx_pkg::word_type                 ks_ff;

   // Sequencer.
   logic                              busy_ff, busy_in;
   phx_pkg::upc_type                  upc_ff, upc_in;
   logic [phx_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   phx_pkg::uop_type                  uop;

   // Response register.
   logic                              rsp_valid_ff;
   phx_pkg::word_type                 rsp_data_ff;
   logic                              rsp_mac_ff;
   logic                              rsp_last_ff;

   logic                              out_free;
   logic                              step_go;
   logic                              loop_back;
   logic                              prog_end;
   logic                              req_accept;
   logic                              csr_write;
   phx_pkg::word_type                 x_word;
   phx_pkg::upc_type                  entry;
   logic [phx_pkg::CNT_W-1:0]         cnt_value;

   function automatic phx_pkg::word_type key_word(
      input logic [3:0][phx_pkg::DWORD_W-1:0] keys,
      input logic [2:0] j
   );
      phx_pkg::word_type w;
      if (j[0]) begin
         w = keys[j[2:1]][phx_pkg::DWORD_W-1:phx_pkg::WORD_W];
      end else begin
         w = keys[j[2:1]][phx_pkg::WORD_W-1:0];
      end
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration port. Writes complete in the access phase; reads return
   // the register selected by the address, zero-extended.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         bump_ff <= '0;
      end else if (csr_write) begin
         unique case (paddr[5:3])
            phx_pkg::CSR_KEY01: key_ff[0] <= pwdata;
            phx_pkg::CSR_KEY23: key_ff[1] <= pwdata;
            phx_pkg::CSR_KEY45: key_ff[2] <= pwdata;
            phx_pkg::CSR_KEY67: key_ff[3] <= pwdata;
            phx_pkg::CSR_BUMP:  bump_ff   <= pwdata[phx_pkg::WORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[5:3])
         phx_pkg::CSR_KEY01: prdata = key_ff[0];
         phx_pkg::CSR_KEY23: prdata = key_ff[1];
         phx_pkg::CSR_KEY45: prdata = key_ff[2];
         phx_pkg::CSR_KEY67: prdata = key_ff[3];
         phx_pkg::CSR_BUMP:  prdata = {{(phx_pkg::CSR_DW-phx_pkg::WORD_W){1'b0}}, bump_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer control. A step that emits waits until the response register
   // is free; every other step runs at once. The last step of a program
   // lets the next request in during the same cycle.
   // ---------------------------------------------------------------------
   assign uop        = phx_pkg::ucode(upc_ff);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign step_go    = busy_ff && ((uop.emit == phx_pkg::EMIT_NONE) || out_free);
   assign loop_back  = uop.loop && (cnt_ff != phx_pkg::CNT_W'(1));
   assign prog_end   = step_go && uop.done && !loop_back;
   assign req_ch.ready = !busy_ff || prog_end;
   assign req_accept = req_ch.valid && req_ch.ready;

   assign cnt_value = (uop.cnt_sel == phx_pkg::CNT_MAC) ?
                      phx_pkg::CNT_W'(phx_pkg::MAC_WORDS) :
                      phx_pkg::CNT_W'(phx_pkg::MAC_PREMIX);

   always_comb begin
      unique case (phx_pkg::action_type'(req_ch.action))
         phx_pkg::ACT_NONCE:   entry = phx_pkg::ENTRY_NONCE;
         phx_pkg::ACT_ENCRYPT: entry = phx_pkg::ENTRY_ENCRYPT;
         phx_pkg::ACT_FINAL:   entry = phx_pkg::ENTRY_FINAL;
         default:              entry = phx_pkg::ENTRY_IGNORE;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      cnt_in  = cnt_ff;
      if (step_go) begin
         if (loop_back) begin
            upc_in = uop.target;
            cnt_in = cnt_ff - phx_pkg::CNT_W'(1);
         end else begin
            upc_in = upc_ff + phx_pkg::UPC_W'(1);
            if (uop.cnt_load) begin
               cnt_in = cnt_value;
            end
         end
         if (prog_end) begin
            busy_in = 1'b0;
         end
      end
      if (req_accept) begin
         busy_in = 1'b1;
         upc_in  = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= phx_pkg::ENTRY_IGNORE;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         nonce_ff <= {req_ch.nonce_high, req_ch.nonce_low};
         plain_ff <= req_ch.plain_word;
      end
   end

   // ---------------------------------------------------------------------
   // Datapath: at most one half round per step. The operand comes from the key
   // schedule, the plaintext, or the second schedule plus the word index, or is zero.
   // ---------------------------------------------------------------------
   always_comb begin
      case (uop.x_sel)
         phx_pkg::X_KEY:   x_word = key_word(key_ff, idx_ff[2:0]);
         phx_pkg::X_PLAIN: x_word = plain_ff;
         phx_pkg::X_SCHED: x_word = ss_ff[idx_ff[2:0]] + idx_ff;
         default:          x_word = '0;
      endcase
   end

   always_comb begin
      z_in   = z_ff;
      old_in = old_ff;
      ss_in  = ss_ff;
      idx_in = idx_ff;
      if (step_go) begin
         case (uop.op)
            phx_pkg::OP_INIT: begin
               for (int k = 0; k < 4; k++) begin
                  ss_in[k]   = key_word(key_ff, 3'(k + 4)) + nonce_ff[k];
                  ss_in[k+4] = key_word(key_ff, 3'(k)) + (32'(k) - nonce_ff[k]);
                  z_in[k]    = key_word(key_ff, 3'(k + 3)) ^ nonce_ff[k];
               end
               ss_in[1] = key_word(key_ff, 3'd5) + nonce_ff[1] + bump_ff;
               ss_in[5] = key_word(key_ff, 3'd1) + (32'd1 - nonce_ff[1]) + bump_ff;
               z_in[4]  = key_word(key_ff, 3'd7);
               idx_in   = '0;
            end
            phx_pkg::OP_HALF_A: z_in = phx_pkg::half_a(z_ff, x_word);
            phx_pkg::OP_HALF_B: z_in = phx_pkg::half_b(z_ff, x_word);
            phx_pkg::OP_SAVE:   z_in[0] = z_ff[0] ^ phx_pkg::MAC_MAGIC;
            phx_pkg::OP_RESTORE: begin
               z_in   = zsave_ff;
               old_in = oldsave_ff;
               idx_in = idxsave_ff;
            end
            default: ;
         endcase
         // End of a mixing word: remember the last z4 and advance the index.
         if (uop.old_wr) begin
            old_in[idx_ff[1:0]] = z_in[4];
            idx_in = idx_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_ff   <= '0;
         old_ff <= '0;
         ss_ff  <= '0;
         idx_ff <= '0;
      end else begin
         z_ff   <= z_in;
         old_ff <= old_in;
         ss_ff  <= ss_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && (uop.op == phx_pkg::OP_SAVE)) begin
         zsave_ff   <= z_ff;
         oldsave_ff <= old_ff;
         idxsave_ff <= idx_ff;
      end
   end

   // The keystream word is z4 after the key halves plus the old word; it is
   // taken from the registered state so that it does not lengthen the half-round path.
   always_ff @(posedge clock) begin
      if (step_go && uop.ks_cap) begin
         ks_ff <= z_ff[4] + old_ff[idx_ff[1:0]];
      end
   end

   // ---------------------------------------------------------------------
   // Response register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go && (uop.emit != phx_pkg::EMIT_NONE)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && (uop.emit == phx_pkg::EMIT_CIPHER)) begin
         rsp_data_ff <= ks_ff ^ plain_ff;
         rsp_mac_ff  <= 1'b0;
         rsp_last_ff <= 1'b1;
      end else if (step_go && (uop.emit == phx_pkg::EMIT_MAC)) begin
         rsp_data_ff <= ks_ff;
         rsp_mac_ff  <= 1'b1;
         rsp_last_ff <= (cnt_ff == phx_pkg::CNT_W'(1));
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.data_word = rsp_data_ff;
   assign rsp_ch.is_mac    = rsp_mac_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule
